// ===== sv/ssaa_pkg.sv =====
// ----------------------------------------------------------------------------
// ssaa_pkg
// Shared constants, types and the reciprocal table of the box downsampler.
// ----------------------------------------------------------------------------
package ssaa_pkg;

    localparam int MAX_OUT_WIDTH = 1024;
    localparam int MAX_KERNEL    = 8;
    localparam int HEIGHT_LIMIT  = 1024;

    localparam int COL_W = $clog2(MAX_OUT_WIDTH);
    localparam int ROW_W = $clog2(HEIGHT_LIMIT);
    localparam int SUB_W = $clog2(MAX_KERNEL);

    // one channel sum holds up to MAX_KERNEL^2 * 255
    localparam int CH_W  = 14;
    localparam int SUM_W = 3 * CH_W;

    localparam int PIX_W = 8;

    localparam int KSIZE_W  = 4;
    localparam int DIM_W    = 11;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_KERNEL = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [KSIZE_W-1:0] KSIZE_RESET  = 4'd1;
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 11'd480;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // quotient = (sum * ceil(2^RECIP_SHIFT / k^2)) >> RECIP_SHIFT, exact for sums below 2^CH_W
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = CH_W + RECIP_W;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [COL_W-1:0] col;
        logic [SUB_W-1:0] kmin1;
        logic             first;
        logic             emit;
        logic             row_end;
        logic             frame_end;
    } ssaa_job_t;

    localparam int JOB_W = $bits(ssaa_job_t);

    typedef struct packed {
        logic empty;
        logic pop;
    } ssaa_qctl_t;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [SUB_W-1:0] kmin1);
        logic [RECIP_W-1:0] m;
        begin
            case (kmin1)
                3'd0:    m = 21'd1048576;
                3'd1:    m = 21'd262144;
                3'd2:    m = 21'd116509;
                3'd3:    m = 21'd65536;
                3'd4:    m = 21'd41944;
                3'd5:    m = 21'd29128;
                3'd6:    m = 21'd21400;
                3'd7:    m = 21'd16384;
                default: m = 21'd1048576;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== sv/ssaa_ram.sv =====
// ----------------------------------------------------------------------------
// ssaa_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/ssaa_front.sv =====
// ----------------------------------------------------------------------------
// ssaa_front
// Configuration registers, pixel position counters and classification of
// each incoming pixel into a job for the accumulate side.
// ----------------------------------------------------------------------------
module ssaa_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssaa_pkg::ADDR_W-1:0]   paddr,
    input  logic [ssaa_pkg::DATA_W-1:0]   pwdata,
    output logic [ssaa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic [ssaa_pkg::PIX_W-1:0]    red_in,
    input  logic [ssaa_pkg::PIX_W-1:0]    green_in,
    input  logic [ssaa_pkg::PIX_W-1:0]    blue_in,
    input  logic                          accept,
    output ssaa_pkg::ssaa_job_t           job
);

    logic [ssaa_pkg::KSIZE_W-1:0] ksize_reg;
    logic [ssaa_pkg::DIM_W-1:0]   width_reg;
    logic [ssaa_pkg::DIM_W-1:0]   height_reg;

    logic [ssaa_pkg::SUB_W-1:0] sub_col_reg, sub_col_next;
    logic [ssaa_pkg::COL_W-1:0] col_reg, col_next;
    logic [ssaa_pkg::SUB_W-1:0] sub_row_reg, sub_row_next;
    logic [ssaa_pkg::ROW_W-1:0] row_reg, row_next;

    logic [ssaa_pkg::SUB_W-1:0] kmin1;
    logic [ssaa_pkg::COL_W-1:0] wmin1;
    logic [ssaa_pkg::ROW_W-1:0] hmin1;

    logic       wr_en;
    logic       wr_hit;
    logic [1:0] reg_idx;
    logic       last_sub_col;
    logic       last_col;
    logic       last_sub_row;
    logic       last_row;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign wr_hit  = wr_en & ((reg_idx == ssaa_pkg::REG_KERNEL) ||
                              (reg_idx == ssaa_pkg::REG_WIDTH) ||
                              (reg_idx == ssaa_pkg::REG_HEIGHT));

    always_comb
    begin
        case (reg_idx)
            ssaa_pkg::REG_KERNEL: prdata = ssaa_pkg::DATA_W'(ksize_reg);
            ssaa_pkg::REG_WIDTH:  prdata = ssaa_pkg::DATA_W'(width_reg);
            ssaa_pkg::REG_HEIGHT: prdata = ssaa_pkg::DATA_W'(height_reg);
            default:              prdata = '0;
        endcase
    end

    // clamp the registers to their working ranges, kept as value minus one
    always_comb
    begin
        if (ksize_reg == '0)
            kmin1 = '0;
        else if (ksize_reg > ssaa_pkg::KSIZE_W'(ssaa_pkg::MAX_KERNEL))
            kmin1 = ssaa_pkg::SUB_W'(ssaa_pkg::MAX_KERNEL - 1);
        else
            kmin1 = ssaa_pkg::SUB_W'(ksize_reg - 1'b1);

        if (width_reg == '0)
            wmin1 = '0;
        else if (width_reg > ssaa_pkg::DIM_W'(ssaa_pkg::MAX_OUT_WIDTH))
            wmin1 = ssaa_pkg::COL_W'(ssaa_pkg::MAX_OUT_WIDTH - 1);
        else
            wmin1 = ssaa_pkg::COL_W'(width_reg - 1'b1);

        if (height_reg == '0)
            hmin1 = '0;
        else if (height_reg > ssaa_pkg::DIM_W'(ssaa_pkg::HEIGHT_LIMIT))
            hmin1 = ssaa_pkg::ROW_W'(ssaa_pkg::HEIGHT_LIMIT - 1);
        else
            hmin1 = ssaa_pkg::ROW_W'(height_reg - 1'b1);
    end

    assign last_sub_col = (sub_col_reg == kmin1);
    assign last_col     = (col_reg == wmin1);
    assign last_sub_row = (sub_row_reg == kmin1);
    assign last_row     = (row_reg == hmin1);

    always_comb
    begin
        job.red       = red_in;
        job.green     = green_in;
        job.blue      = blue_in;
        job.col       = col_reg;
        job.kmin1     = kmin1;
        job.first     = (sub_col_reg == '0) && (sub_row_reg == '0);
        job.emit      = last_sub_col & last_sub_row;
        job.row_end   = last_col;
        job.frame_end = last_col & last_row;
    end

    always_comb
    begin
        sub_col_next = sub_col_reg;
        col_next     = col_reg;
        sub_row_next = sub_row_reg;
        row_next     = row_reg;
        if (wr_hit)
        begin
            sub_col_next = '0;
            col_next     = '0;
            sub_row_next = '0;
            row_next     = '0;
        end
        else if (accept)
        begin
            if (!last_sub_col)
            begin
                sub_col_next = sub_col_reg + 1'b1;
            end
            else
            begin
                sub_col_next = '0;
                if (!last_col)
                begin
                    col_next = col_reg + 1'b1;
                end
                else
                begin
                    col_next = '0;
                    if (!last_sub_row)
                    begin
                        sub_row_next = sub_row_reg + 1'b1;
                    end
                    else
                    begin
                        sub_row_next = '0;
                        row_next     = last_row ? '0 : row_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ksize_reg   <= ssaa_pkg::KSIZE_RESET;
            width_reg   <= ssaa_pkg::WIDTH_RESET;
            height_reg  <= ssaa_pkg::HEIGHT_RESET;
            sub_col_reg <= '0;
            col_reg     <= '0;
            sub_row_reg <= '0;
            row_reg     <= '0;
        end
        else
        begin
            if (wr_en && reg_idx == ssaa_pkg::REG_KERNEL)
                ksize_reg <= pwdata[ssaa_pkg::KSIZE_W-1:0];
            if (wr_en && reg_idx == ssaa_pkg::REG_WIDTH)
                width_reg <= pwdata[ssaa_pkg::DIM_W-1:0];
            if (wr_en && reg_idx == ssaa_pkg::REG_HEIGHT)
                height_reg <= pwdata[ssaa_pkg::DIM_W-1:0];
            sub_col_reg <= sub_col_next;
            col_reg     <= col_next;
            sub_row_reg <= sub_row_next;
            row_reg     <= row_next;
        end
    end

endmodule

// ===== sv/ssaa_queue.sv =====
// ----------------------------------------------------------------------------
// ssaa_queue
// Short job queue between the classify side and the accumulate side.
// ----------------------------------------------------------------------------
module ssaa_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ssaa_pkg::ssaa_job_t  wr_job,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output ssaa_pkg::ssaa_job_t  rd_job
);

    ssaa_pkg::ssaa_job_t entry_reg [ssaa_pkg::QUEUE_DEPTH];

    logic [ssaa_pkg::QPTR_W-1:0] wptr_reg, wptr_next;
    logic [ssaa_pkg::QPTR_W-1:0] rptr_reg, rptr_next;
    logic [ssaa_pkg::QPTR_W:0]   count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign full    = (count_reg == (ssaa_pkg::QPTR_W+1)'(ssaa_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_job  = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/ssaa_back.sv =====
// ----------------------------------------------------------------------------
// ssaa_back
// Accumulate side: read-modify-write of the column sums, divide by k squared
// through a reciprocal multiply, and the output word register.
// ----------------------------------------------------------------------------
module ssaa_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    output ssaa_pkg::ssaa_qctl_t         qctl,
    input  ssaa_pkg::ssaa_job_t          q_job,
    output logic                         ram_re,
    output logic [ssaa_pkg::COL_W-1:0]   ram_raddr,
    input  logic [ssaa_pkg::SUM_W-1:0]   ram_rdata,
    output logic                         ram_we,
    output logic [ssaa_pkg::COL_W-1:0]   ram_waddr,
    output logic [ssaa_pkg::SUM_W-1:0]   ram_wdata,
    output logic [ssaa_pkg::PIX_W-1:0]   red_out,
    output logic [ssaa_pkg::PIX_W-1:0]   green_out,
    output logic [ssaa_pkg::PIX_W-1:0]   blue_out,
    output logic                         row_end,
    output logic                         frame_end,
    output logic                         empty,
    input  logic                         pop
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    localparam int CW = ssaa_pkg::CH_W;

    logic [1:0]                     state_reg, state_next;
    ssaa_pkg::ssaa_job_t            job_reg;
    logic [ssaa_pkg::SUM_W-1:0]     sum_reg;
    logic [ssaa_pkg::RECIP_W-1:0]   recip_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [ssaa_pkg::PIX_W-1:0]     red_reg, green_reg, blue_reg;
    logic                           row_end_reg, frame_end_reg;

    logic [CW-1:0]                  sum_r, sum_g, sum_b;
    logic [ssaa_pkg::PROD_W-1:0]    prod_r, prod_g, prod_b;
    logic                           take;
    logic                           load;

    assign take = (state_reg == ST_IDLE) & ~q_empty;
    assign load = (state_reg == ST_DIV) & (~out_valid_reg | pop);

    assign qctl.empty = q_empty;
    assign qctl.pop   = take;

    assign ram_re    = take;
    assign ram_raddr = q_job.col;

    // first pixel of a block overwrites the stale column sum
    always_comb
    begin
        if (job_reg.first)
        begin
            sum_r = CW'(job_reg.red);
            sum_g = CW'(job_reg.green);
            sum_b = CW'(job_reg.blue);
        end
        else
        begin
            sum_r = ram_rdata[0*CW +: CW] + CW'(job_reg.red);
            sum_g = ram_rdata[1*CW +: CW] + CW'(job_reg.green);
            sum_b = ram_rdata[2*CW +: CW] + CW'(job_reg.blue);
        end
    end

    assign ram_we    = (state_reg == ST_SUM);
    assign ram_waddr = job_reg.col;
    assign ram_wdata = {sum_b, sum_g, sum_r};

    assign prod_r = ssaa_pkg::PROD_W'(sum_reg[0*CW +: CW]) * ssaa_pkg::PROD_W'(recip_reg);
    assign prod_g = ssaa_pkg::PROD_W'(sum_reg[1*CW +: CW]) * ssaa_pkg::PROD_W'(recip_reg);
    assign prod_b = ssaa_pkg::PROD_W'(sum_reg[2*CW +: CW]) * ssaa_pkg::PROD_W'(recip_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = job_reg.emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & ~pop;
        if (load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= q_job;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg   <= ram_wdata;
            recip_reg <= ssaa_pkg::recip_of(job_reg.kmin1);
        end
        if (load)
        begin
            red_reg       <= prod_r[ssaa_pkg::RECIP_SHIFT +: ssaa_pkg::PIX_W];
            green_reg     <= prod_g[ssaa_pkg::RECIP_SHIFT +: ssaa_pkg::PIX_W];
            blue_reg      <= prod_b[ssaa_pkg::RECIP_SHIFT +: ssaa_pkg::PIX_W];
            row_end_reg   <= job_reg.row_end;
            frame_end_reg <= job_reg.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty     = ~out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

// ===== sv/ssaa_box_downsample_unit.sv =====
// Path: a block's last pixel passes queue entry, job, sum and output word registers, waiting
// while the prior output word is held. Throughput: the accumulate loop takes one queued pixel
// at a time (column-sum read, write back, then reciprocal multiply for a block's last pixel);
// a 4-word queue absorbs bursts at one pixel per cycle on the input side while not full.
// Reset: asynchronous, active low; registers return to k=1, 640x480, counters zero.
// The column-sum RAM is not cleared; each block's first pixel overwrites its entry.
// ----------------------------------------------------------------------------
// ssaa_box_downsample_unit
// Supersampling box-filter downsampler: averages each k-by-k block of an
// RGB raster stream into one output pixel with row and frame end marks.
// ----------------------------------------------------------------------------
module ssaa_box_downsample_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssaa_pkg::ADDR_W-1:0]   paddr,
    input  logic [ssaa_pkg::DATA_W-1:0]   pwdata,
    output logic [ssaa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic [ssaa_pkg::PIX_W-1:0]    red_in,
    input  logic [ssaa_pkg::PIX_W-1:0]    green_in,
    input  logic [ssaa_pkg::PIX_W-1:0]    blue_in,
    input  logic                          push,
    output logic                          full,
    output logic [ssaa_pkg::PIX_W-1:0]    red_out,
    output logic [ssaa_pkg::PIX_W-1:0]    green_out,
    output logic [ssaa_pkg::PIX_W-1:0]    blue_out,
    output logic                          row_end,
    output logic                          frame_end,
    output logic                          empty,
    input  logic                          pop
);

    ssaa_pkg::ssaa_job_t          in_job;
    ssaa_pkg::ssaa_job_t          q_job;
    ssaa_pkg::ssaa_qctl_t         qctl;
    logic                         q_empty;
    logic                         accept;
    logic                         ram_re;
    logic                         ram_we;
    logic [ssaa_pkg::COL_W-1:0]   ram_raddr;
    logic [ssaa_pkg::COL_W-1:0]   ram_waddr;
    logic [ssaa_pkg::SUM_W-1:0]   ram_rdata;
    logic [ssaa_pkg::SUM_W-1:0]   ram_wdata;

    assign accept = push & ~full;

    ssaa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .accept   (accept),
        .job      (in_job)
    );

    ssaa_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (in_job),
        .full   (full),
        .pop    (qctl.pop),
        .empty  (q_empty),
        .rd_job (q_job)
    );

    ssaa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .qctl      (qctl),
        .q_job     (q_job),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .row_end   (row_end),
        .frame_end (frame_end),
        .empty     (empty),
        .pop       (pop)
    );

    ssaa_ram #(
        .WIDTH (ssaa_pkg::SUM_W),
        .DEPTH (ssaa_pkg::MAX_OUT_WIDTH)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!frame_end || row_end))
        else $error("frame end without row end");

    a_no_read_during_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("column sum read while write back pending");

    a_read_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (!q_empty && qctl.pop))
        else $error("column sum read without a queued job");

    a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> ram_we)
        else $error("write back did not follow read");

endmodule
